// File: sv/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

    // Field and word widths
    localparam int COORD_W    = 8;
    localparam int COORD_MAX  = 255;
    localparam int ITER_W     = 16;
    localparam int CLASS_W    = 3;
    localparam int PIX_X_W    = 9;
    localparam int Q_W        = 32;
    localparam int ZOOM_W     = 31;
    localparam int FRAC_BITS  = 28;
    localparam int PROD64_W   = 64;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    // Defaults handed to the top level
    localparam int GRID_SIZE_DEF   = 200;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SCREEN_WIDTH    = 320;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_RE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_IM = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZOOM      = 2'd3;

    // Register reset values
    localparam logic [ITER_W-1:0]        MAX_ITER_RST  = 16'd50;
    localparam logic signed [Q_W-1:0]    CENTER_RST    = 32'sd0;
    localparam logic [ZOOM_W-1:0]        ZOOM_RST      = 31'd536870912;

    // Colour classes
    localparam logic [CLASS_W-1:0] CLS_NONE      = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_BLACK     = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_DARK_BLUE = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_LIGHT_RED = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_DARK_RED  = 3'd4;

    // |z|^2 limit of 4.0 in Q8.56
    localparam logic [PROD64_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

    localparam logic signed [PROD64_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [PROD64_W-1:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [ITER_W-1:0]     max_iter;
        logic signed [Q_W-1:0] center_re;
        logic signed [Q_W-1:0] center_im;
        logic [ZOOM_W-1:0]     zoom;
    } cfg_t;

    // One mapped point on its way to the iteration engine
    typedef struct packed {
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
        logic [PIX_X_W-1:0]    pixel_x;
        logic [COORD_W-1:0]    pixel_y;
    } point_t;

    // Clamp a wide signed value to the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD64_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[Q_W-1:0];
        end
        else if (v < SAT_LO) begin
            res = SAT_LO[Q_W-1:0];
        end
        else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Band the escape count by quarters of the limit
    function automatic logic [CLASS_W-1:0] color_class(input logic [ITER_W-1:0] count,
                                                       input logic [ITER_W-1:0] limit);
        logic [ITER_W:0]    quarter;
        logic [ITER_W:0]    half;
        logic [ITER_W:0]    three_q;
        logic [ITER_W:0]    cnt;
        logic [CLASS_W-1:0] cls;
        quarter = {3'b000, limit[ITER_W-1:2]};
        half    = {2'b00, limit[ITER_W-1:1]};
        three_q = quarter + {quarter[ITER_W-1:0], 1'b0};
        cnt     = {1'b0, count};
        if (count == limit) begin
            cls = CLS_BLACK;
        end
        else if (cnt < quarter) begin
            cls = CLS_NONE;
        end
        else if (cnt < half) begin
            cls = CLS_DARK_BLUE;
        end
        else if (cnt < three_q) begin
            cls = CLS_LIGHT_RED;
        end
        else begin
            cls = CLS_DARK_RED;
        end
        return cls;
    endfunction

endpackage

// File: sv/mep_cfg_regs.sv
`timescale 1ns / 1ps

module mep_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mep_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mep_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output mep_pkg::cfg_t                  cfg
);
    import mep_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iter  <= MAX_ITER_RST;
            cfg_reg.center_re <= CENTER_RST;
            cfg_reg.center_im <= CENTER_RST;
            cfg_reg.zoom      <= ZOOM_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_ITER:  cfg_reg.max_iter  <= pwdata[ITER_W-1:0];
                REG_CENTER_RE: cfg_reg.center_re <= $signed(pwdata[Q_W-1:0]);
                REG_CENTER_IM: cfg_reg.center_im <= $signed(pwdata[Q_W-1:0]);
                REG_ZOOM:      cfg_reg.zoom      <= pwdata[ZOOM_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_MAX_ITER:  prdata = APB_DATA_W'(cfg_reg.max_iter);
            REG_CENTER_RE: prdata = APB_DATA_W'($unsigned(cfg_reg.center_re));
            REG_CENTER_IM: prdata = APB_DATA_W'($unsigned(cfg_reg.center_im));
            REG_ZOOM:      prdata = APB_DATA_W'(cfg_reg.zoom);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: sv/mep_mapper.sv
`timescale 1ns / 1ps

module mep_mapper #(
    parameter int GRID_SIZE = mep_pkg::GRID_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mep_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mep_pkg::COORD_W-1:0] column,
    input  logic [mep_pkg::COORD_W-1:0] row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mep_pkg::point_t             out_point
);
    import mep_pkg::*;

    // Offset range of 2*pos - GRID_SIZE and the product widths that follow
    localparam int SPAN_HI   = (2 * COORD_MAX > GRID_SIZE) ? 2 * COORD_MAX - GRID_SIZE : 0;
    localparam int MAG_MAX   = (GRID_SIZE > SPAN_HI) ? GRID_SIZE : SPAN_HI;
    localparam int MAG_W     = $clog2(MAG_MAX + 1);
    localparam int GRID_W    = $clog2(GRID_SIZE + 1);
    localparam int DIFF_W    = ((COORD_W + 1 > GRID_W) ? COORD_W + 1 : GRID_W) + 1;
    localparam int PROD_W    = MAG_W + ZOOM_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (PROD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int REM_W     = $clog2(GRID_SIZE) + 1;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int SUM_W     = ((PROD_W + 1 > Q_W) ? PROD_W + 1 : Q_W) + 1;
    localparam int MARGIN    = (GRID_SIZE < SCREEN_WIDTH) ? (SCREEN_WIDTH - GRID_SIZE) / 2 : 0;

    localparam logic [REM_W-1:0]         DIVISOR   = REM_W'(GRID_SIZE);
    localparam logic signed [DIFF_W-1:0] GRID_DIFF = DIFF_W'(GRID_SIZE);
    localparam logic [STEP_W-1:0]        LAST_STEP = STEP_W'(DIV_STEPS - 1);
    localparam logic [PIX_X_W-1:0]       MARGIN_X  = PIX_X_W'(MARGIN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic               neg_re_reg;
    logic               neg_im_reg;
    logic [PAD_W-1:0]   num_re_reg;
    logic [PAD_W-1:0]   num_im_reg;
    logic [PAD_W-1:0]   quo_re_reg;
    logic [PAD_W-1:0]   quo_im_reg;
    logic [REM_W-1:0]   rem_re_reg;
    logic [REM_W-1:0]   rem_im_reg;

    logic signed [DIFF_W-1:0] diff_re;
    logic signed [DIFF_W-1:0] diff_im;
    logic signed [DIFF_W-1:0] abs_re;
    logic signed [DIFF_W-1:0] abs_im;
    logic [MAG_W-1:0]         mag_re;
    logic [MAG_W-1:0]         mag_im;
    logic [REM_W-1:0]         rem_re_step;
    logic [REM_W-1:0]         rem_im_step;
    logic [DIV_BITS-1:0]      quo_re_step;
    logic [DIV_BITS-1:0]      quo_im_step;
    logic signed [SUM_W-1:0]  qmag_re;
    logic signed [SUM_W-1:0]  qmag_im;
    logic signed [SUM_W-1:0]  val_re;
    logic signed [SUM_W-1:0]  val_im;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;

    // Restoring division by the grid size, DIV_BITS quotient bits per call
    function automatic logic [REM_W+DIV_BITS-1:0] div_step(input logic [REM_W-1:0]    rem_in,
                                                         input logic [DIV_BITS-1:0] bits_in);
        logic [REM_W-1:0]    rem;
        logic [DIV_BITS-1:0] quo;
        rem = rem_in;
        quo = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            rem = {rem[REM_W-2:0], bits_in[i]};
            if (rem >= DIVISOR) begin
                rem    = rem - DIVISOR;
                quo[i] = 1'b1;
            end
        end
        return {rem, quo};
    endfunction

    // Signed offsets from the grid centre and their magnitudes
    always_comb
    begin
        diff_re = $signed({{(DIFF_W - COORD_W - 1){1'b0}}, col_reg, 1'b0}) - GRID_DIFF;
        diff_im = $signed({{(DIFF_W - COORD_W - 1){1'b0}}, row_reg, 1'b0}) - GRID_DIFF;
        abs_re  = diff_re[DIFF_W-1] ? -diff_re : diff_re;
        abs_im  = diff_im[DIFF_W-1] ? -diff_im : diff_im;
        mag_re  = abs_re[MAG_W-1:0];
        mag_im  = abs_im[MAG_W-1:0];
    end

    assign {rem_re_step, quo_re_step} = div_step(rem_re_reg, num_re_reg[PAD_W-1 -: DIV_BITS]);
    assign {rem_im_step, quo_im_step} = div_step(rem_im_reg, num_im_reg[PAD_W-1 -: DIV_BITS]);

    // Restore the sign, add the real centre, subtract the imaginary centre and clamp
    always_comb
    begin
        qmag_re = $signed(SUM_W'(quo_re_reg[PROD_W-1:0]));
        qmag_im = $signed(SUM_W'(quo_im_reg[PROD_W-1:0]));
        val_re  = neg_re_reg ? -qmag_re : qmag_re;
        val_im  = neg_im_reg ? -qmag_im : qmag_im;
        sum_re  = val_re + SUM_W'(cfg.center_re);
        sum_im  = val_im - SUM_W'(cfg.center_im);
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = (state_reg == ST_PUSH);
    assign out_point.c_re    = sat32(PROD64_W'(sum_re));
    assign out_point.c_im    = sat32(PROD64_W'(sum_im));
    assign out_point.pixel_x = PIX_X_W'(col_reg) + MARGIN_X;
    assign out_point.pixel_y = row_reg;

    // Sequence one item through multiply, divide and push
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == '0) state_next = ST_PUSH;
            ST_PUSH: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                step_reg <= LAST_STEP;
            end
            else if (state_reg == ST_DIV && step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // Datapath: capture, scale by zoom, then shift the quotient out
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_reg <= column;
                    row_reg <= row;
                end
            end
            ST_MUL:
            begin
                num_re_reg <= PAD_W'(PROD_W'(mag_re) * PROD_W'(cfg.zoom));
                num_im_reg <= PAD_W'(PROD_W'(mag_im) * PROD_W'(cfg.zoom));
                neg_re_reg <= diff_re[DIFF_W-1];
                neg_im_reg <= diff_im[DIFF_W-1];
                rem_re_reg <= '0;
                rem_im_reg <= '0;
            end
            ST_DIV:
            begin
                num_re_reg <= {num_re_reg[PAD_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
                num_im_reg <= {num_im_reg[PAD_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
                quo_re_reg <= {quo_re_reg[PAD_W-DIV_BITS-1:0], quo_re_step};
                quo_im_reg <= {quo_im_reg[PAD_W-DIV_BITS-1:0], quo_im_step};
                rem_re_reg <= rem_re_step;
                rem_im_reg <= rem_im_step;
            end
            default:
            begin
                col_reg <= col_reg;
            end
        endcase
    end

endmodule

// File: sv/mep_queue.sv
`timescale 1ns / 1ps

module mep_queue #(
    parameter int DEPTH = mep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mep_pkg::point_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mep_pkg::point_t out_data
);
    import mep_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

    point_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty queue with pointers apart");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == FULL_CNT |-> rd_ptr_reg == wr_ptr_reg)
        else $error("full queue with pointers apart");

endmodule

// File: sv/mep_iterate.sv
`timescale 1ns / 1ps

module mep_iterate (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mep_pkg::ITER_W-1:0]  max_iter,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mep_pkg::point_t             in_point,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mep_pkg::ITER_W-1:0]  iter_count,
    output logic [mep_pkg::CLASS_W-1:0] color_class,
    output logic [mep_pkg::PIX_X_W-1:0] pixel_x,
    output logic [mep_pkg::COORD_W-1:0] pixel_y
);
    import mep_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [Q_W-1:0]       c_re_reg;
    logic signed [Q_W-1:0]       c_im_reg;
    logic signed [Q_W-1:0]       x_reg;
    logic signed [Q_W-1:0]       y_reg;
    logic [ITER_W-1:0]           count_reg;
    logic [PIX_X_W-1:0]          pix_x_reg;
    logic [COORD_W-1:0]          pix_y_reg;
    logic signed [PROD64_W-1:0]  xx_reg;
    logic signed [PROD64_W-1:0]  yy_reg;
    logic signed [PROD64_W-1:0]  xy_reg;
    logic [ITER_W-1:0]           out_count_reg;
    logic [CLASS_W-1:0]          out_class_reg;
    logic [PIX_X_W-1:0]          out_pix_x_reg;
    logic [COORD_W-1:0]          out_pix_y_reg;

    logic [PROD64_W-1:0]         sq_sum;
    logic                        stop;
    logic signed [PROD64_W-1:0]  re_diff;
    logic signed [PROD64_W-1:0]  re_sum;
    logic signed [PROD64_W-1:0]  im_sum;
    logic signed [Q_W-1:0]       x_next;
    logic signed [Q_W-1:0]       y_next;
    logic                        pop;
    logic                        load_out;

    // Escape test and next iterate from the registered products
    always_comb
    begin
        sq_sum  = $unsigned(xx_reg) + $unsigned(yy_reg);
        stop    = (sq_sum >= ESCAPE_LIMIT) || (count_reg >= max_iter);
        re_diff = xx_reg - yy_reg;
        re_sum  = (re_diff >>> FRAC_BITS) + PROD64_W'(c_re_reg);
        im_sum  = (xy_reg >>> (FRAC_BITS - 1)) + PROD64_W'(c_im_reg);
        x_next  = sat32(re_sum);
        y_next  = sat32(im_sum);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign pop      = in_valid && in_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_TEST;
            ST_TEST: state_next = stop ? ST_DONE : ST_MUL;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Iterate z = z^2 + c: products registered in ST_MUL, add and test in ST_TEST
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            c_re_reg  <= in_point.c_re;
            c_im_reg  <= in_point.c_im;
            x_reg     <= in_point.c_re;
            y_reg     <= in_point.c_im;
            pix_x_reg <= in_point.pixel_x;
            pix_y_reg <= in_point.pixel_y;
            count_reg <= ITER_W'(1);
        end
        if (state_reg == ST_MUL)
        begin
            xx_reg <= PROD64_W'(x_reg) * PROD64_W'(x_reg);
            yy_reg <= PROD64_W'(y_reg) * PROD64_W'(y_reg);
            xy_reg <= PROD64_W'(x_reg) * PROD64_W'(y_reg);
        end
        if (state_reg == ST_TEST && !stop)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_reg + 1'b1;
        end
        if (load_out)
        begin
            out_count_reg <= count_reg;
            out_class_reg <= mep_pkg::color_class(count_reg, max_iter);
            out_pix_x_reg <= pix_x_reg;
            out_pix_y_reg <= pix_y_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign iter_count  = out_count_reg;
    assign color_class = out_class_reg;
    assign pixel_x     = out_pix_x_reg;
    assign pixel_y     = out_pix_y_reg;

    a_square_sign: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TEST |-> !xx_reg[PROD64_W-1] && !yy_reg[PROD64_W-1])
        else $error("negative square reached the escape test");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> count_reg != '0)
        else $error("iteration count zero while busy");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result register loaded outside the finish step");

endmodule

// File: sv/mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps
// The mapper takes an item only when idle and holds it through capture, zoom multiply,
// a restoring divide by GRID_SIZE four quotient bits per step, and push to the queue.
// The iterator takes a new point only after the last result is loaded; its loop computes the
// three 32x32 products in its multiply state, then the escape test and update in its test state.
// Reset: rst_n clears all control state and loads the registers with their reset values.
module mandelbrot_escape_pixel #(
    parameter int GRID_SIZE   = mep_pkg::GRID_SIZE_DEF,
    parameter int QUEUE_DEPTH = mep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mep_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // column[7:0], row[15:8]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // iter_count[15:0], color_class[18:16],
                                                            // pixel_x[27:19], pixel_y[35:28], zero
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mep_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mep_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mep_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mep_pkg::*;

    localparam int OUT_PAD_W = OUT_TDATA_W - ITER_W - CLASS_W - PIX_X_W - COORD_W;

    cfg_t               cfg;
    point_t             map_point;
    point_t             q_point;
    logic               map_valid;
    logic               map_ready;
    logic               q_valid;
    logic               q_ready;
    logic [ITER_W-1:0]  iter_count;
    logic [CLASS_W-1:0] color_class;
    logic [PIX_X_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    mep_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: map the pixel to c
    mep_mapper #(
        .GRID_SIZE (GRID_SIZE)
    ) u_mapper (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .column    (s_axis_tdata[COORD_W-1:0]),
        .row       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_point (map_point)
    );

    // Decouple mapping from iteration
    mep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_data   (map_point),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_point)
    );

    // Back: escape-time iteration and colour banding
    mep_iterate u_iterate (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_iter    (cfg.max_iter),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_point    (q_point),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .iter_count  (iter_count),
        .color_class (color_class),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, pixel_y, pixel_x, color_class, iter_count};

endmodule
